FILE: rtl/assert_macros.svh
// Assertion macros shared by the hasher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of the clock while reset is low.
`define SHA1H_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define SHA1H_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `SHA1H_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

FILE: rtl/sha1h_pkg.sv
// Types and constants shared by the SHA-1 byte stream hasher.
package sha1h_pkg;

  localparam int NUM_WORDS = 5;

  localparam logic [31:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_00_19 = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_IDX   = 3'd4;
  // Last byte position that still leaves room for 0x80 plus the length field.
  localparam logic [5:0] LAST_SHORT_POS = 6'd55;

  typedef enum logic [1:0] {
    ACT_ABSORB  = 2'd0,
    ACT_FINISH  = 2'd1,
    ACT_RESTART = 2'd2
  } action_e_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_TOO_LONG     = 2'd1,
    ERR_AFTER_FINISH = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FOLD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic      push;
    byte_sel_t sel;
    logic      clear_msg;
    logic      clear_len;
    logic      load_work;
    logic      step;
    logic [6:0] rnd;
    logic      fold;
    logic      emit;
    logic [2:0] emit_idx;
    logic      emit_last;
    logic      emit_err;
    err_t      status;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_len;
    logic pos_short;
    logic count_full;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/sha1h_if.sv
// Valid/ready channel interfaces for message input and digest output.
interface sha1h_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha1h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic [1:0]  status;

  modport source (output valid, digest_word, word_index, last_word, status, input ready);
  modport sink (input valid, digest_word, word_index, last_word, status, output ready);
endinterface

FILE: rtl/sha1h_datapath.sv
// Message schedule, round logic, hash state and output register of the hasher.
`include "assert_macros.svh"

module sha1h_datapath import sha1h_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [7:0] data_byte,
  output stat_t      stat,
  sha1h_out_if.source dig
);

  logic [31:0]  hash [NUM_WORDS];
  logic [511:0] blk;
  logic [5:0]   pos;
  logic [60:0]  byte_cnt;
  logic [31:0]  wa, wb, wc, wd, we;

  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [7:0]  push_byte;
  logic [31:0] w0, w2, w8, w13, w_mix, w_new;
  logic [31:0] f_val, k_val, t_sum;

  assign len_bits = {byte_cnt, 3'b000};
  // Length goes out most significant byte first at positions 56 to 63.
  assign len_byte = len_bits[{~pos[2:0], 3'b000} +: 8];

  always_comb begin
    unique case (cmd.sel)
      SEL_DATA: push_byte = data_byte;
      SEL_PAD:  push_byte = PAD_BYTE;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = len_byte;
      default:  push_byte = 8'h00;
    endcase
  end

  // The block register is a 16-word window; word 0 sits at the top.
  assign w0    = blk[511:480];
  assign w2    = blk[447:416];
  assign w8    = blk[255:224];
  assign w13   = blk[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    priority if (cmd.rnd < 7'd20) begin
      f_val = (wb & wc) | (~wb & wd);
      k_val = K_00_19;
    end else if (cmd.rnd < 7'd40) begin
      f_val = wb ^ wc ^ wd;
      k_val = K_20_39;
    end else if (cmd.rnd < 7'd60) begin
      f_val = (wb & wc) | (wb & wd) | (wc & wd);
      k_val = K_40_59;
    end else begin
      f_val = wb ^ wc ^ wd;
      k_val = K_60_79;
    end
  end

  assign t_sum = {wa[26:0], wa[31:27]} + f_val + we + w0 + k_val;

  assign stat.pos_last   = &pos;
  assign stat.pos_len    = &pos[5:3];
  assign stat.pos_short  = (pos <= LAST_SHORT_POS);
  assign stat.count_full = &byte_cnt;
  assign stat.out_free   = !dig.valid || dig.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) hash[i] <= H_INIT[i];
      pos       <= '0;
      byte_cnt  <= '0;
      dig.valid <= 1'b0;
    end else begin
      if (cmd.clear_msg) begin
        for (int i = 0; i < NUM_WORDS; i++) hash[i] <= H_INIT[i];
      end else if (cmd.fold) begin
        hash[0] <= hash[0] + wa;
        hash[1] <= hash[1] + wb;
        hash[2] <= hash[2] + wc;
        hash[3] <= hash[3] + wd;
        hash[4] <= hash[4] + we;
      end

      if (cmd.clear_msg) begin
        pos <= '0;
      end else if (cmd.push) begin
        pos <= pos + 6'd1;
      end

      if (cmd.clear_msg || cmd.clear_len) begin
        byte_cnt <= '0;
      end else if (cmd.push && cmd.sel == SEL_DATA) begin
        byte_cnt <= byte_cnt + 61'd1;
      end

      if (cmd.emit) begin
        dig.valid <= 1'b1;
      end else if (dig.ready) begin
        dig.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[503:0], push_byte};
    end else if (cmd.step) begin
      blk <= {blk[479:0], w_new};
    end

    if (cmd.load_work) begin
      wa <= hash[0];
      wb <= hash[1];
      wc <= hash[2];
      wd <= hash[3];
      we <= hash[4];
    end else if (cmd.step) begin
      wa <= t_sum;
      wb <= wa;
      wc <= {wb[1:0], wb[31:2]};
      wd <= wc;
      we <= wd;
    end

    if (cmd.emit) begin
      dig.digest_word <= cmd.emit_err ? 32'h0 : hash[cmd.emit_idx];
      dig.word_index  <= cmd.emit_idx;
      dig.last_word   <= cmd.emit_last;
      dig.status      <= cmd.status;
    end
  end

  `SHA1H_ASSERT(a_emit_free, clk, rst, cmd.emit |-> (!dig.valid || dig.ready), "emit overwrote a waiting word")
  `SHA1H_ASSERT_NEVER(a_push_step, clk, rst, cmd.push && (cmd.step || cmd.fold), "push during compression")

endmodule

FILE: rtl/sha1h_ctrl.sv
// Sequencer for absorbing, padding, compression rounds and digest output.
`include "assert_macros.svh"

module sha1h_ctrl import sha1h_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t     state, state_next;
  logic       finished;
  err_t       err_code;
  logic       finishing;
  logic       len_blk;
  logic [6:0] rnd;
  logic [2:0] emit_idx;
  logic       emit_err;

  logic in_fire;
  logic is_absorb, is_finish, is_restart;
  logic absorb_ok, absorb_err, finish_err, finish_rep, finish_new;
  logic emit_done;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign is_absorb  = (in_action == ACT_ABSORB);
  assign is_finish  = (in_action == ACT_FINISH);
  assign is_restart = (in_action == ACT_RESTART);

  assign absorb_ok  = is_absorb && !finished && (err_code == ERR_NONE);
  assign absorb_err = is_absorb && !absorb_ok;
  assign finish_err = is_finish && (err_code != ERR_NONE);
  assign finish_rep = is_finish && (err_code == ERR_NONE) && finished;
  assign finish_new = is_finish && (err_code == ERR_NONE) && !finished;
  assign emit_done  = stat.out_free && (emit_err || emit_idx == LAST_IDX);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          priority if (absorb_ok || finish_new) begin
            state_next = stat.pos_last ? S_COMP : (absorb_ok ? S_IDLE : S_PAD);
          end else if (absorb_err || finish_err || finish_rep) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PAD:  if (stat.pos_last) state_next = S_COMP;
      S_COMP: if (rnd == LAST_ROUND) state_next = S_FOLD;
      S_FOLD: begin
        if (finishing) state_next = len_blk ? S_EMIT : S_PAD;
        else state_next = S_IDLE;
      end
      S_EMIT: if (emit_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sel       = SEL_ZERO;
    cmd.rnd       = rnd;
    cmd.emit_idx  = emit_idx;
    cmd.emit_err  = emit_err;
    cmd.emit_last = emit_err || (emit_idx == LAST_IDX);
    cmd.status    = emit_err ? err_code : ERR_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (absorb_ok) begin
            cmd.push      = 1'b1;
            cmd.sel       = SEL_DATA;
            cmd.load_work = stat.pos_last;
          end else if (finish_new) begin
            cmd.push      = 1'b1;
            cmd.sel       = SEL_PAD;
            cmd.load_work = stat.pos_last;
          end else if (is_restart) begin
            cmd.clear_msg = 1'b1;
          end
        end
      end
      S_PAD: begin
        cmd.push      = 1'b1;
        cmd.sel       = (stat.pos_len && len_blk) ? SEL_LEN : SEL_ZERO;
        cmd.load_work = stat.pos_last;
      end
      S_COMP: cmd.step = 1'b1;
      S_FOLD: begin
        cmd.fold      = 1'b1;
        cmd.clear_len = finishing && len_blk;
      end
      S_EMIT: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      finished  <= 1'b0;
      err_code  <= ERR_NONE;
      finishing <= 1'b0;
      len_blk   <= 1'b0;
      rnd       <= '0;
      emit_idx  <= '0;
      emit_err  <= 1'b0;
    end else begin
      state <= state_next;

      if (cmd.load_work) begin
        rnd <= '0;
      end else if (state == S_COMP) begin
        rnd <= rnd + 7'd1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            emit_idx <= '0;
            if (absorb_err) begin
              emit_err <= 1'b1;
              if (finished) err_code <= ERR_AFTER_FINISH;
            end else if (absorb_ok) begin
              if (stat.count_full) err_code <= ERR_TOO_LONG;
            end else if (finish_err) begin
              emit_err <= 1'b1;
            end else if (finish_rep) begin
              emit_err <= 1'b0;
            end else if (finish_new) begin
              finishing <= 1'b1;
              len_blk   <= stat.pos_short;
            end else if (is_restart) begin
              finished  <= 1'b0;
              err_code  <= ERR_NONE;
              finishing <= 1'b0;
            end
          end
        end
        S_FOLD: begin
          if (finishing) begin
            if (len_blk) begin
              finishing <= 1'b0;
              finished  <= 1'b1;
              emit_err  <= 1'b0;
              emit_idx  <= '0;
            end else begin
              len_blk <= 1'b1;
            end
          end
        end
        S_EMIT: if (stat.out_free) emit_idx <= emit_idx + 3'd1;
        default: ;
      endcase
    end
  end

  `SHA1H_ASSERT(a_rnd_range, clk, rst, (state == S_COMP) |-> (rnd <= LAST_ROUND), "round count past last round")
  `SHA1H_ASSERT(a_load_wrap, clk, rst, cmd.load_work |-> (cmd.push && stat.pos_last), "compression started without a full block")
  `SHA1H_ASSERT_NEVER(a_fin_both, clk, rst, finished && finishing, "finish flags overlap")
  `SHA1H_ASSERT(a_fold_next, clk, rst, (state == S_COMP && rnd == LAST_ROUND) |=> (state == S_FOLD), "fold did not follow last round")

endmodule

FILE: rtl/sha1_byte_stream_hasher.sv
// Top level of the SHA-1 byte stream hasher.
//
// The msg channel carries one word per message step: action 0 absorbs
// data_byte, action 1 finishes the message and returns the digest, action 2
// starts a new message. Action 3 is accepted and has no effect.
// The dig channel returns the digest as five 32-bit words, most significant
// first, with word_index 0 to 4 and last_word set on the fifth. An error
// (absorb after finish, or a message that reaches 2^64 bits) returns a single
// word with digest_word 0, last_word set and the error code in status.
// Each absorbed byte is shifted into the block register; the 64th byte of a
// block starts the compression (80 rounds of one shared round unit, then the
// hash update), and no new byte is taken until it is done. Finish pushes
// the pad byte, zero bytes and the length field, compresses each of the one
// or two blocks, then loads the digest words while the output is free.
// msg.ready is high only while no item is in work. Digest words sit in an
// output register; when dig.ready is low the block holds the word and waits.
// Once the last word is loaded the block takes new input even if that word
// is still waiting. Synchronous reset loads the initial hash and clears the
// byte count, the flags and the output valid.
module sha1_byte_stream_hasher import sha1h_pkg::*; (
  input logic clk,
  input logic rst,
  sha1h_in_if.sink    msg,
  sha1h_out_if.source dig
);

  cmd_t  cmd;
  stat_t stat;

  sha1h_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg.valid),
    .in_action (msg.action),
    .in_ready  (msg.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sha1h_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (msg.data_byte),
    .stat      (stat),
    .dig       (dig)
  );

endmodule
